@@ rtl/core/dsdl_pkg.sv @@
// Package for the depth-sorted draw list: sizes, item and result codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package dsdl_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int SLOT_W      = $clog2(MAX_ENTRIES);
  localparam int LINK_W      = $clog2(MAX_ENTRIES + 1);
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_ENTRIES);

  localparam int KEY_W  = 32;
  localparam int VERT_W = 4;
  localparam int COL_W  = 8;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DRAIN  = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_RETURNED  = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic       take;
    logic       clear;
    logic       ins_write;
    logic       link_head;
    logic       walk_start;
    logic       walk_next;
    logic       link_tail;
    logic       advance;
    logic       link_x;
    logic       drain_read;
    logic       drain_pick;
    logic       set_code;
    logic [1:0] code;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       empty;
    logic       key_gt;
    logic       link_null;
    logic       drain_empty;
    logic       out_free;
  } dp_stat_t;

endpackage

@@ rtl/core/dsdl_if.sv @@
// Item and result channel interfaces of the depth-sorted draw list.
// Depends on dsdl_pkg for field widths.
interface dsdl_cmd_if
  import dsdl_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic signed [KEY_W-1:0] depth;
  logic [VERT_W-1:0]       vertex_count;
  logic [COL_W-1:0]        colour;

  modport source(output valid, kind, depth, vertex_count, colour, input ready);
  modport sink(input valid, kind, depth, vertex_count, colour, output ready);
endinterface

interface dsdl_rsp_if
  import dsdl_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [SLOT_W-1:0]       slot;
  logic signed [KEY_W-1:0] depth_out;
  logic [VERT_W-1:0]       vertex_count_out;
  logic [COL_W-1:0]        colour_out;
  logic                    last;

  modport source(output valid, status, slot, depth_out, vertex_count_out, colour_out,
                 last, input ready);
  modport sink(input valid, status, slot, depth_out, vertex_count_out, colour_out,
               last, output ready);
endinterface

@@ rtl/core/dsdl_datapath.sv @@
// Datapath of the depth-sorted draw list: entry stores, list pointers,
// walk registers and the result register. Depends on dsdl_pkg.
module dsdl_datapath
  import dsdl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_cmd_t               cmd,
  output dp_stat_t                stat,
  input  logic [1:0]              kind,
  input  logic signed [KEY_W-1:0] depth,
  input  logic [VERT_W-1:0]       vertex_count,
  input  logic [COL_W-1:0]        colour,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output logic [1:0]              status,
  output logic [SLOT_W-1:0]       slot,
  output logic signed [KEY_W-1:0] depth_out,
  output logic [VERT_W-1:0]       vertex_count_out,
  output logic [COL_W-1:0]        colour_out,
  output logic                    last
);

  logic [KEY_W-1:0]  key_mem    [MAX_ENTRIES];
  logic [LINK_W-1:0] link_mem   [MAX_ENTRIES];
  logic [VERT_W-1:0] vertex_mem [MAX_ENTRIES];
  logic [COL_W-1:0]  colour_mem [MAX_ENTRIES];

  logic [KEY_W-1:0]  key_q;
  logic [LINK_W-1:0] link_q;
  logic [VERT_W-1:0] vert_q;
  logic [COL_W-1:0]  col_q;

  logic [LINK_W-1:0] count;
  logic [SLOT_W-1:0] head;
  logic [LINK_W-1:0] cursor;
  logic [SLOT_W-1:0] walk_i;
  logic [SLOT_W-1:0] walk_nx;

  logic [1:0]              kind_r;
  logic signed [KEY_W-1:0] key_r;
  logic [VERT_W-1:0]       vert_r;
  logic [COL_W-1:0]        col_r;
  logic [1:0]              status_r;
  logic [SLOT_W-1:0]       slot_r;

  logic [SLOT_W-1:0] new_slot;
  logic              cursor_null;
  logic [LINK_W-1:0] drain_s;
  logic              drain_empty;
  logic              drain_hit;
  logic              returned;

  logic              link_we;
  logic [SLOT_W-1:0] link_waddr;
  logic [LINK_W-1:0] link_wdata;
  logic              link_rd;
  logic [SLOT_W-1:0] link_raddr;
  logic              key_rd;
  logic [SLOT_W-1:0] key_raddr;

  assign new_slot    = count[SLOT_W-1:0];
  assign cursor_null = (cursor >= LINK_NULL);
  assign drain_s     = cursor_null ? ((count != '0) ? LINK_W'(head) : LINK_NULL) : link_q;
  assign drain_empty = (drain_s >= LINK_NULL) || (drain_s >= count);
  assign drain_hit   = cmd.drain_pick && !drain_empty;
  assign returned    = (status_r == ST_RETURNED);

  assign stat.kind        = kind_r;
  assign stat.full        = (count >= LINK_W'(MAX_ENTRIES));
  assign stat.empty       = (count == '0);
  assign stat.key_gt      = (key_r > $signed(key_q));
  assign stat.link_null   = (link_q >= LINK_NULL);
  assign stat.drain_empty = drain_empty;
  assign stat.out_free    = !rsp_valid || rsp_ready;

  // Link store port selection
  always_comb begin
    link_we    = 1'b0;
    link_waddr = slot_r;
    link_wdata = LINK_NULL;
    if (cmd.ins_write) begin
      link_we    = 1'b1;
      link_waddr = new_slot;
      link_wdata = LINK_NULL;
    end else if (cmd.link_head) begin
      link_we    = 1'b1;
      link_waddr = slot_r;
      link_wdata = LINK_W'(head);
    end else if (cmd.link_tail) begin
      link_we    = 1'b1;
      link_waddr = walk_i;
      link_wdata = LINK_W'(slot_r);
    end else if (cmd.link_x) begin
      link_we    = 1'b1;
      link_waddr = slot_r;
      link_wdata = LINK_W'(walk_nx);
    end

    link_rd = cmd.walk_start || cmd.walk_next || cmd.drain_read || drain_hit;
    if (cmd.walk_start) begin
      link_raddr = head;
    end else if (cmd.walk_next) begin
      link_raddr = link_q[SLOT_W-1:0];
    end else if (cmd.drain_read) begin
      link_raddr = cursor[SLOT_W-1:0];
    end else begin
      link_raddr = drain_s[SLOT_W-1:0];
    end

    key_rd = cmd.ins_write || cmd.walk_next || drain_hit;
    if (cmd.ins_write) begin
      key_raddr = head;
    end else if (cmd.walk_next) begin
      key_raddr = link_q[SLOT_W-1:0];
    end else begin
      key_raddr = drain_s[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_rd) begin
      link_q <= link_mem[link_raddr];
    end
    if (cmd.ins_write) begin
      key_mem[new_slot]    <= key_r;
      vertex_mem[new_slot] <= vert_r;
      colour_mem[new_slot] <= col_r;
    end
    if (key_rd) begin
      key_q <= key_mem[key_raddr];
    end
    if (drain_hit) begin
      vert_q <= vertex_mem[drain_s[SLOT_W-1:0]];
      col_q  <= colour_mem[drain_s[SLOT_W-1:0]];
    end
  end

  // List pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      head   <= '0;
      cursor <= LINK_NULL;
    end else if (cmd.clear) begin
      count  <= '0;
      head   <= '0;
      cursor <= LINK_NULL;
    end else begin
      if (cmd.ins_write) begin
        count <= count + LINK_W'(1);
      end
      if (cmd.link_head) begin
        head <= slot_r;
      end
      if (drain_hit) begin
        cursor <= drain_s;
      end
    end
  end

  // Item and walk registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_r   <= kind;
      key_r    <= depth;
      vert_r   <= vertex_count;
      col_r    <= colour;
      status_r <= ST_DONE;
      slot_r   <= '0;
    end
    if (cmd.ins_write) begin
      slot_r <= new_slot;
    end
    if (drain_hit) begin
      slot_r <= drain_s[SLOT_W-1:0];
    end
    if (cmd.set_code) begin
      status_r <= cmd.code;
    end
    if (cmd.walk_start) begin
      walk_i <= head;
    end
    if (cmd.walk_next) begin
      walk_nx <= link_q[SLOT_W-1:0];
    end
    if (cmd.advance) begin
      walk_i <= walk_nx;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status           <= status_r;
      slot             <= slot_r;
      depth_out        <= returned ? $signed(key_q) : '0;
      vertex_count_out <= returned ? vert_q : '0;
      colour_out       <= returned ? col_q : '0;
      last             <= returned && (link_q >= LINK_NULL);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= LINK_W'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_cursor_live: assert property (@(posedge clk) disable iff (rst)
    cursor_null || (cursor < count))
    else $error("drain cursor points past the stored entries");

  a_head_live: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> (LINK_W'(head) < count))
    else $error("head slot outside the stored entries");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || rsp_ready))
    else $error("pending result overwritten");

endmodule

@@ rtl/core/dsdl_ctrl.sv @@
// Controller of the depth-sorted draw list: sequences clear, insert walk
// and drain over the datapath. Depends on dsdl_pkg.
module dsdl_ctrl
  import dsdl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECODE   = 8'b0000_0010,
    S_INS_HEAD = 8'b0000_0100,
    S_WALK_NX  = 8'b0000_1000,
    S_WALK_CMP = 8'b0001_0000,
    S_LINK_X   = 8'b0010_0000,
    S_DRN_LNK  = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.kind)
          KIND_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_RESP;
          end
          KIND_INSERT: begin
            if (stat.full) begin
              cmd.set_code = 1'b1;
              cmd.code     = ST_FULL;
              state_next   = S_RESP;
            end else begin
              cmd.ins_write = 1'b1;
              // first entry becomes the head on its own
              state_next    = stat.empty ? S_RESP : S_INS_HEAD;
            end
          end
          KIND_DRAIN: begin
            cmd.drain_read = 1'b1;
            state_next     = S_DRN_LNK;
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_INS_HEAD: begin
        if (stat.key_gt) begin
          cmd.link_head = 1'b1;
          state_next    = S_RESP;
        end else begin
          cmd.walk_start = 1'b1;
          state_next     = S_WALK_NX;
        end
      end
      S_WALK_NX: begin
        if (stat.link_null) begin
          cmd.link_tail = 1'b1;
          state_next    = S_RESP;
        end else begin
          cmd.walk_next = 1'b1;
          state_next    = S_WALK_CMP;
        end
      end
      S_WALK_CMP: begin
        if (stat.key_gt) begin
          cmd.link_tail = 1'b1;
          state_next    = S_LINK_X;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_WALK_NX;
        end
      end
      S_LINK_X: begin
        cmd.link_x = 1'b1;
        state_next = S_RESP;
      end
      S_DRN_LNK: begin
        cmd.drain_pick = 1'b1;
        cmd.set_code   = 1'b1;
        cmd.code       = stat.drain_empty ? ST_EXHAUSTED : ST_RETURNED;
        state_next     = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> (state == S_DECODE))
    else $error("accepted item not decoded");

  a_one_link_write: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.ins_write, cmd.link_head, cmd.link_tail, cmd.link_x}) <= 1)
    else $error("two link writes in one cycle");

  a_load_then_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> in_ready)
    else $error("not ready after result load");

endmodule

@@ rtl/core/depth_sorted_draw_list_core.sv @@
// Top level of the depth-sorted draw list. Instantiates dsdl_ctrl and
// dsdl_datapath; depends on dsdl_pkg and the channel interfaces in dsdl_if.
//
// Keeps up to 128 entries linked in descending depth order; equal depths keep
// arrival order. One item is handled at a time and each gives one result. A
// clear, an unused kind or a dropped insert goes from decode straight to the
// result state; a drain reads the link of the cursor and then picks the next
// entry or reports the list exhausted. An insert into an empty list goes from
// its write straight to the result state; one that becomes the new head is
// compared with the head and linked before it. Any other insert walks the
// linked order from the head through the link store, which has one read port:
// each further visited entry costs one link read and one key read with compare,
// and an insert linked between two entries takes one more link write than one
// linked at the tail. The next item can be accepted in the cycle after the
// result is loaded into the output register, which holds it until taken.
module depth_sorted_draw_list_core
  import dsdl_pkg::*;
(
  input logic        clk,
  input logic        rst,
  dsdl_cmd_if.sink   cmd,
  dsdl_rsp_if.source rsp
);

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  dsdl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .stat     (stat),
    .cmd      (ctl)
  );

  dsdl_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (ctl),
    .stat             (stat),
    .kind             (cmd.kind),
    .depth            (cmd.depth),
    .vertex_count     (cmd.vertex_count),
    .colour           (cmd.colour),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .status           (rsp.status),
    .slot             (rsp.slot),
    .depth_out        (rsp.depth_out),
    .vertex_count_out (rsp.vertex_count_out),
    .colour_out       (rsp.colour_out),
    .last             (rsp.last)
  );

endmodule
